// ===== hdl/dsa_collision_filter_top_defines.svh =====
// ----------------------------------------------------------------------------
// Collision filter assertion macros
// Shared property macros for the collision filter top level.
// ----------------------------------------------------------------------------
`ifndef DSA_COLLISION_FILTER_TOP_DEFINES_SVH
`define DSA_COLLISION_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DCF_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("collision filter property failed");
`define DCF_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("collision filter property failed");
`else
`define DCF_ASSERT_IMP(name, clk, rst, ante, cons)
`define DCF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/dcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Collision filter package
// Field widths, table geometry and shared types of the collision filter.
// ----------------------------------------------------------------------------
package dcf_pkg;

  localparam int COUNT_W     = 4;
  localparam int TERM_W      = 16;
  localparam int PID_W       = 32;
  localparam int PAIR_W      = TERM_W + PID_W;
  localparam int TOTAL_W     = 16;
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);

  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(TABLE_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic shift;
    logic load_new;
    logic clear;
  } chain_ctrl_t;

endpackage

// ===== hdl/dcf_in_if.sv =====
// ----------------------------------------------------------------------------
// Slot input channel
// Valid/ready channel that carries one random-access slot per transfer.
// ----------------------------------------------------------------------------
interface dcf_in_if;
  logic                        valid;
  logic                        ready;
  logic [dcf_pkg::COUNT_W-1:0] packet_count;
  logic [dcf_pkg::TERM_W-1:0]  terminal_id;
  logic [dcf_pkg::PID_W-1:0]   packet_id;
  logic                        last_slot;

  modport source (output valid, packet_count, terminal_id, packet_id, last_slot,
                  input ready);
  modport sink (input valid, packet_count, terminal_id, packet_id, last_slot,
                output ready);
endinterface

// ===== hdl/dcf_out_if.sv =====
// ----------------------------------------------------------------------------
// Slot result channel
// Valid/ready channel that carries one slot decision per transfer.
// ----------------------------------------------------------------------------
interface dcf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accept;
  logic [dcf_pkg::TERM_W-1:0]  out_terminal_id;
  logic [dcf_pkg::PID_W-1:0]   out_packet_id;
  logic [dcf_pkg::TOTAL_W-1:0] collision_total;
  logic                        frame_done;

  modport source (output valid, accept, out_terminal_id, out_packet_id,
                  collision_total, frame_done, input ready);
  modport sink (input valid, accept, out_terminal_id, out_packet_id,
                collision_total, frame_done, output ready);
endinterface

// ===== hdl/dcf_cell.sv =====
// ----------------------------------------------------------------------------
// Collision filter table cell
// Holds one accepted pair and its valid flag and passes both to its neighbor.
// ----------------------------------------------------------------------------
module dcf_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  dcf_pkg::chain_ctrl_t       ctrl,
  input  logic [dcf_pkg::PAIR_W-1:0] pair_in,
  input  logic                       valid_in,
  output logic [dcf_pkg::PAIR_W-1:0] pair,
  output logic                       valid
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      pair <= pair_in;
    end
  end

endmodule

// ===== hdl/dcf_chain.sv =====
// ----------------------------------------------------------------------------
// Collision filter cell ring
// Row of table cells that rotates past a comparator at its tail, or takes a
// new pair in at its head.
// ----------------------------------------------------------------------------
module dcf_chain (
  input  logic                       clk,
  input  logic                       rst,
  input  dcf_pkg::chain_ctrl_t       ctrl,
  input  logic [dcf_pkg::PAIR_W-1:0] key,
  output logic                       hit
);

  logic [dcf_pkg::PAIR_W-1:0] pair_link  [dcf_pkg::TABLE_DEPTH];
  logic                       valid_link [dcf_pkg::TABLE_DEPTH];
  logic [dcf_pkg::PAIR_W-1:0] head_pair;
  logic                       head_valid;

  assign head_pair  = ctrl.load_new ? key : pair_link[dcf_pkg::TABLE_DEPTH-1];
  assign head_valid = ctrl.load_new ? 1'b1 : valid_link[dcf_pkg::TABLE_DEPTH-1];

  for (genvar i = 0; i < dcf_pkg::TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      dcf_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .pair_in  (head_pair),
        .valid_in (head_valid),
        .pair     (pair_link[i]),
        .valid    (valid_link[i])
      );
    end else begin : g_body
      dcf_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .pair_in  (pair_link[i-1]),
        .valid_in (valid_link[i-1]),
        .pair     (pair_link[i]),
        .valid    (valid_link[i])
      );
    end
  end

  assign hit = valid_link[dcf_pkg::TABLE_DEPTH-1]
               && (pair_link[dcf_pkg::TABLE_DEPTH-1] == key);

endmodule

// ===== hdl/dsa_collision_filter_top.sv =====
// ----------------------------------------------------------------------------
// A single-packet slot that meets a nonempty table waits in SEARCH for one turn of the 64-cell
// ring past its comparator before FINISH; every other slot goes from IDLE straight to FINISH.
// Slots are handled one at a time: a new slot is taken only in IDLE, after FINISH loads the result.
// Reset: synchronous; clears the table valid flags, fill count, collision total.
// ----------------------------------------------------------------------------
`include "dsa_collision_filter_top_defines.svh"

module dsa_collision_filter_top #(
  parameter int MAX_PACKETS_PER_SLOT = 15
) (
  input  logic             clk,
  input  logic             rst,
  dcf_in_if.sink           slot_in,
  dcf_out_if.source        result_out
);

  localparam logic [7:0] MaxPkts = 8'(MAX_PACKETS_PER_SLOT);

  dcf_pkg::state_t                 state;
  dcf_pkg::state_t                 state_next;
  dcf_pkg::chain_ctrl_t            ctrl;

  logic [dcf_pkg::COUNT_W-1:0]     item_count;
  logic [dcf_pkg::TERM_W-1:0]      item_term;
  logic [dcf_pkg::PID_W-1:0]       item_pid;
  logic                            item_last;

  logic [dcf_pkg::IDX_W-1:0]       search_cnt;
  logic                            hit;
  logic                            chain_hit;
  logic [dcf_pkg::FILL_W-1:0]      fill;
  logic [dcf_pkg::TOTAL_W-1:0]     coll;
  logic [dcf_pkg::TOTAL_W-1:0]     coll_next;

  logic                            out_valid;
  logic                            in_xfer;
  logic                            can_load;
  logic                            finish_load;
  logic                            res_acc;
  logic                            do_insert;
  logic [dcf_pkg::COUNT_W-1:0]     add;
  logic [dcf_pkg::TOTAL_W:0]       sum;

  assign in_xfer     = slot_in.valid && slot_in.ready;
  assign can_load    = !out_valid || result_out.ready;
  assign finish_load = (state == dcf_pkg::ST_FINISH) && can_load;
  assign res_acc     = (item_count == dcf_pkg::COUNT_ONE) && !hit;
  assign do_insert   = finish_load && res_acc && (fill < dcf_pkg::FILL_FULL);

  dcf_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .key  ({item_term, item_pid}),
    .hit  (chain_hit)
  );

  // Packet counts above the per-slot limit are counted at the limit.
  always_comb begin
    if ({4'b0, item_count} > MaxPkts) begin
      add = MaxPkts[dcf_pkg::COUNT_W-1:0];
    end else begin
      add = item_count;
    end
    sum = {1'b0, coll} + (dcf_pkg::TOTAL_W+1)'(add);
    if (item_count > dcf_pkg::COUNT_ONE) begin
      coll_next = sum[dcf_pkg::TOTAL_W] ? dcf_pkg::TOTAL_MAX : sum[dcf_pkg::TOTAL_W-1:0];
    end else begin
      coll_next = coll;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dcf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if ((slot_in.packet_count == dcf_pkg::COUNT_ONE) && (fill != '0)) begin
            state_next = dcf_pkg::ST_SEARCH;
          end else begin
            state_next = dcf_pkg::ST_FINISH;
          end
        end
      end
      dcf_pkg::ST_SEARCH: begin
        if (search_cnt == dcf_pkg::LAST_IDX) begin
          state_next = dcf_pkg::ST_FINISH;
        end
      end
      dcf_pkg::ST_FINISH: begin
        if (can_load) begin
          state_next = dcf_pkg::ST_IDLE;
        end
      end
      default: state_next = dcf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    slot_in.ready = 1'b0;
    ctrl          = '0;
    unique case (state)
      dcf_pkg::ST_IDLE: begin
        slot_in.ready = 1'b1;
      end
      dcf_pkg::ST_SEARCH: begin
        ctrl.shift = 1'b1;
      end
      dcf_pkg::ST_FINISH: begin
        ctrl.shift    = do_insert;
        ctrl.load_new = do_insert;
        ctrl.clear    = finish_load && item_last;
      end
      default: begin
        slot_in.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_count <= slot_in.packet_count;
      item_term  <= slot_in.terminal_id;
      item_pid   <= slot_in.packet_id;
      item_last  <= slot_in.last_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      search_cnt <= '0;
      hit        <= 1'b0;
    end else if (in_xfer) begin
      search_cnt <= '0;
      hit        <= 1'b0;
    end else if (state == dcf_pkg::ST_SEARCH) begin
      search_cnt <= search_cnt + 1'b1;
      hit        <= hit || chain_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      coll <= '0;
    end else if (finish_load) begin
      if (item_last) begin
        fill <= '0;
        coll <= '0;
      end else begin
        coll <= coll_next;
        if (do_insert) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_load) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_load) begin
      result_out.accept          <= res_acc;
      result_out.out_terminal_id <= res_acc ? item_term : '0;
      result_out.out_packet_id   <= res_acc ? item_pid : '0;
      result_out.collision_total <= coll_next;
      result_out.frame_done      <= item_last;
    end
  end

  assign result_out.valid = out_valid;

  `DCF_ASSERT_IMP(a_search_single, clk, rst, state == dcf_pkg::ST_SEARCH, item_count == dcf_pkg::COUNT_ONE)
  `DCF_ASSERT_NXT(a_frame_clear, clk, rst, finish_load && item_last, (fill == '0) && (coll == '0))
  `DCF_ASSERT_NXT(a_fill_grow, clk, rst, do_insert && !item_last, fill == dcf_pkg::FILL_W'($past(fill) + 1'b1))

endmodule

// ===== dv/dsa_collision_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// Collision filter testbench
// Streams random-access slots into the collision filter. The slots include
// edge values, replicas, frames that fill the pair store, and random frames.
// A local model predicts each slot decision, and every result transfer is
// checked field by field.
// ----------------------------------------------------------------------------
module dsa_collision_filter_top_tb;
  import dcf_pkg::*;

  localparam int MAX_LOST_PER_SLOT = 15;
  localparam int RANDOM_SLOTS      = 1360;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TERM_W-1:0]  term;
    logic [PID_W-1:0]   pid;
    logic               last;
  } slot_t;

  typedef struct packed {
    logic               accept;
    logic [TERM_W-1:0]  term;
    logic [PID_W-1:0]   pid;
    logic [TOTAL_W-1:0] total;
    logic               done;
  } decision_t;

  logic clk;
  logic rst;

  dcf_in_if  slot_in();
  dcf_out_if result_out();

  dsa_collision_filter_top #(
    .MAX_PACKETS_PER_SLOT(MAX_LOST_PER_SLOT)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .slot_in    (slot_in),
    .result_out (result_out)
  );

  slot_t              pending_slots[$];
  decision_t          expected_decisions[$];
  logic [PAIR_W-1:0]  delivered_pairs[$];
  logic [TOTAL_W-1:0] lost_total;
  int                 slots_taken;
  int                 errors;
  logic               quiet;

  assign quiet = (slots_taken >= 600) && (slots_taken < 800);

  function automatic decision_t judge_slot(slot_t s);
    decision_t          d;
    logic [PAIR_W-1:0]  key;
    logic               seen;
    logic [TOTAL_W:0]   sum;
    logic [COUNT_W-1:0] lost;
    d    = '0;
    key  = {s.term, s.pid};
    seen = 1'b0;
    if (s.count == COUNT_ONE) begin
      foreach (delivered_pairs[i]) begin
        if (delivered_pairs[i] == key) seen = 1'b1;
      end
      if (!seen) begin
        d.accept = 1'b1;
        d.term   = s.term;
        d.pid    = s.pid;
        if (delivered_pairs.size() < TABLE_DEPTH) begin
          delivered_pairs.insert(delivered_pairs.size(), key);
        end
      end
    end else if (s.count > COUNT_ONE) begin
      lost = (s.count > MAX_LOST_PER_SLOT) ? COUNT_W'(MAX_LOST_PER_SLOT) : s.count;
      sum  = lost_total + lost;
      lost_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
    d.total = lost_total;
    d.done  = s.last;
    if (s.last) begin
      delivered_pairs.delete();
      lost_total = '0;
    end
    return d;
  endfunction

  task automatic queue_slot(int count, logic [TERM_W-1:0] term, logic [PID_W-1:0] pid,
                            logic last);
    slot_t s;
    s.count = COUNT_W'(count);
    s.term  = term;
    s.pid   = pid;
    s.last  = last;
    pending_slots.insert(pending_slots.size(), s);
  endtask

  task automatic report_field(string name, logic [PAIR_W-1:0] want, logic [PAIR_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic build_random_frames();
    logic [PAIR_W-1:0] frame_pairs[$];
    logic [PAIR_W-1:0] old_pairs[$];
    logic [PAIR_W-1:0] pair;
    int                made;
    int                len;
    int                roll;
    made = 0;
    while (made < RANDOM_SLOTS) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 64) : $urandom_range(65, 96);
      frame_pairs.delete();
      for (int i = 0; i < len; i++) begin
        roll = $urandom_range(99);
        pair = PAIR_W'({$urandom, $urandom});
        if (roll < 15) begin
          queue_slot(0, pair[47:32], pair[31:0], 1'b0);
        end else if (roll < 60) begin
          roll = $urandom_range(99);
          if (frame_pairs.size() != 0 && roll < 35) begin
            pair = frame_pairs[$urandom_range(frame_pairs.size() - 1)];
          end else if (frame_pairs.size() != 0 && roll < 45) begin
            pair = frame_pairs[$urandom_range(frame_pairs.size() - 1)];
            pair[$urandom_range(PAIR_W - 1)] ^= 1'b1;
          end else if (old_pairs.size() != 0 && roll < 55) begin
            pair = old_pairs[$urandom_range(old_pairs.size() - 1)];
          end
          frame_pairs.insert(frame_pairs.size(), pair);
          if (old_pairs.size() < 200) old_pairs.insert(old_pairs.size(), pair);
          queue_slot(1, pair[47:32], pair[31:0], 1'b0);
        end else begin
          queue_slot($urandom_range(2, 15), pair[47:32], pair[31:0], 1'b0);
        end
        if (i == len - 1 && $urandom_range(19) != 0) pending_slots[$].last = 1'b1;
      end
      made += len;
    end
    pending_slots[$].last = 1'b1;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : drive_slots
    slot_t nxt;
    if (rst) begin
      slot_in.valid <= 1'b0;
    end else if (!slot_in.valid || slot_in.ready) begin
      if (pending_slots.size() != 0 && (quiet || $urandom_range(99) >= 17)) begin
        nxt = pending_slots.pop_front();
        slot_in.valid        <= 1'b1;
        slot_in.packet_count <= nxt.count;
        slot_in.terminal_id  <= nxt.term;
        slot_in.packet_id    <= nxt.pid;
        slot_in.last_slot    <= nxt.last;
      end else begin
        slot_in.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_out.ready <= 1'b0;
    end else begin
      result_out.ready <= quiet || ($urandom_range(99) >= 17);
    end
  end

  always @(posedge clk) begin : predict_slots
    slot_t     s;
    decision_t d;
    if (!rst && slot_in.valid && slot_in.ready) begin
      s.count = slot_in.packet_count;
      s.term  = slot_in.terminal_id;
      s.pid   = slot_in.packet_id;
      s.last  = slot_in.last_slot;
      d       = judge_slot(s);
      expected_decisions.insert(expected_decisions.size(), d);
      slots_taken <= slots_taken + 1;
    end
  end

  always @(posedge clk) begin : check_results
    decision_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      if (expected_decisions.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual accept=%0b total=%0h",
                 $time, result_out.accept, result_out.collision_total);
        errors++;
      end else begin
        want = expected_decisions.pop_front();
        report_field("accept", want.accept, result_out.accept);
        report_field("out_terminal_id", want.term, result_out.out_terminal_id);
        report_field("out_packet_id", want.pid, result_out.out_packet_id);
        report_field("collision_total", want.total, result_out.collision_total);
        report_field("frame_done", want.done, result_out.frame_done);
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    errors               = 0;
    slots_taken          = 0;
    lost_total           = '0;
    slot_in.valid        = 1'b0;
    slot_in.packet_count = '0;
    slot_in.terminal_id  = '0;
    slot_in.packet_id    = '0;
    slot_in.last_slot    = 1'b0;
    result_out.ready     = 1'b0;

    queue_slot(0, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_slot(1, 16'h0000, 32'h0000_0000, 1'b0);
    queue_slot(1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_slot(1, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_slot(1, 16'hFFFF, 32'h0000_0000, 1'b0);
    queue_slot(1, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    queue_slot(2, 16'h5A5A, 32'hA5A5_A5A5, 1'b0);
    queue_slot(15, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_slot(1, 16'h0000, 32'h0000_0000, 1'b0);
    queue_slot(1, 16'h1234, 32'h89AB_CDEF, 1'b1);
    queue_slot(1, 16'h0000, 32'h0000_0000, 1'b0);
    queue_slot(3, 16'h0000, 32'h0000_0000, 1'b0);
    queue_slot(14, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    queue_slot(0, 16'h0000, 32'h0000_0000, 1'b1);

    // Overfill the pair store, then replay one pair that was kept and two that were not.
    for (int i = 0; i < TABLE_DEPTH + 2; i++) queue_slot(1, 16'(i), 32'hC0DE_0000 + i, 1'b0);
    queue_slot(1, 16'(TABLE_DEPTH), 32'hC0DE_0000 + TABLE_DEPTH, 1'b0);
    queue_slot(1, 16'd0, 32'hC0DE_0000, 1'b0);
    queue_slot(1, 16'(TABLE_DEPTH + 1), 32'hC0DE_0000 + TABLE_DEPTH + 1, 1'b1);

    queue_slot(1, 16'hBEEF, 32'h0BAD_F00D, 1'b0);
    queue_slot(2, 16'h0000, 32'h0000_0000, 1'b1);

    build_random_frames();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_slots.size() != 0 || slot_in.valid) @(posedge clk);
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_decisions.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/dcf_pkg.sv
hdl/dcf_in_if.sv
hdl/dcf_out_if.sv
hdl/dcf_cell.sv
hdl/dcf_chain.sv
hdl/dsa_collision_filter_top.sv
dv/dsa_collision_filter_top_tb.sv
